FILE: design/midpoint_circle_outline_unit_defines.svh
// Assertion macros shared by the midpoint circle outline unit.
// Depends on nothing; files that check their own logic include it.
`ifndef MIDPOINT_CIRCLE_OUTLINE_UNIT_DEFINES_SVH
`define MIDPOINT_CIRCLE_OUTLINE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Concurrent check on an explicit clock and active-low reset.
`define MCO_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on the standard block clock and reset.
`define MCO_ASSERT(lbl, prop, msg) \
    `MCO_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`else

`define MCO_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define MCO_ASSERT(lbl, prop, msg)

`endif

`endif

FILE: design/mcircle_pkg.sv
// Types and constants for the midpoint circle outline unit.
// Used by mcircle_core and midpoint_circle_outline_unit; depends on nothing.
package mcircle_pkg;

    localparam int COORD_BITS  = 16;
    localparam int RADIUS_BITS = 14;
    // Decision value range needs one bit of headroom above twice the radius plus sign.
    localparam int DEC_BITS    = RADIUS_BITS + 3;
    localparam int IDX_BITS    = 3;

    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic        [RADIUS_BITS-1:0] t_radius;
    typedef logic signed [DEC_BITS-1:0]    t_dec;
    typedef logic        [IDX_BITS-1:0]    t_idx;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_START   = 1'b1;

    // Slots of the point index within a group.
    localparam t_idx IDX_FIRST      = 3'd0;
    localparam t_idx IDX_CARD_WEST  = 3'd1;
    localparam t_idx IDX_CARD_NORTH = 3'd2;
    localparam t_idx IDX_CARD_SOUTH = 3'd3;
    localparam t_idx IDX_MIRROR_END = 3'd3;
    localparam t_idx IDX_GROUP_END  = 3'd7;

    typedef struct packed {
        logic    cmd;
        t_coord  center_x;
        t_coord  center_y;
        t_radius radius;
    } t_cmd_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   pixel_valid;
        logic   last_pixel;
    } t_pixel_item;

    // Generator state carried from one item to the next.
    typedef struct packed {
        logic    busy;
        logic    cardinal;
        t_idx    idx;
        t_coord  cx;
        t_coord  cy;
        t_radius major;
        t_radius minor;
        t_dec    decision;
    } t_gen_state;

endpackage

FILE: design/midpoint_circle_outline_unit.sv
// Midpoint circle outline unit: top level with state and result registers.
// Each result item is registered and shows in the cycle after its command is accepted.
// Throughput: one item per cycle if not stalled; generator state updates on acceptance.
// Reset (synchronous, active low) leaves the generator idle and the result register empty.
// Depends on mcircle_pkg, mcircle_core and midpoint_circle_outline_unit_defines.svh.
`include "midpoint_circle_outline_unit_defines.svh"

module midpoint_circle_outline_unit
    import mcircle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Command channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cmd_item   i_item,
    // Pixel channel.
    output logic        o_valid,
    input  logic        i_ready,
    output t_pixel_item o_item
);

    // The generator state lives in r_state. Each accepted item is decoded
    // against it by the core in the same cycle: the core produces the pixel
    // and the state for the following item. The pixel lands in the result
    // register, which frees the command side as soon as the downstream
    // consumer takes it, so a new item can be accepted in every cycle.

    t_gen_state  r_state;
    t_gen_state  n_state;
    t_pixel_item r_out;
    t_pixel_item n_out;
    logic        r_out_valid;
    logic        accept;

    mcircle_core u_core (
        .i_state (r_state),
        .i_item  (i_item),
        .o_state (n_state),
        .o_pixel (n_out)
    );

    // The result register can take a new item when it is empty or being drained.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The pixel payload needs no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // An idle generator always sits at the start of a group.
    `MCO_ASSERT(a_idle_clean, !r_state.busy |-> (r_state.idx == IDX_FIRST && !r_state.cardinal), "idle state not cleared")
    // The cardinal phase only runs while busy and only visits its three slots.
    `MCO_ASSERT(a_cardinal_slots, r_state.cardinal |-> (r_state.busy && r_state.idx != IDX_FIRST && r_state.idx <= IDX_CARD_SOUTH), "cardinal phase out of range")
    // The minor offset never overtakes the major offset on a live circle.
    `MCO_ASSERT(a_octant_order, r_state.busy |-> (r_state.major >= r_state.minor), "minor offset exceeds major offset")
    // Every accepted item yields a result item in the next cycle.
    `MCO_ASSERT(a_one_result, (i_valid && o_ready) |=> o_valid, "accepted item produced no result")
    // Only a real pixel can close a circle.
    `MCO_ASSERT(a_last_is_pixel, (r_out_valid && r_out.last_pixel) |-> r_out.pixel_valid, "last flag on an empty result")

endmodule

FILE: design/mcircle_core.sv
// Next-state and pixel logic of the midpoint circle generator for one item.
// Depends on mcircle_pkg.
module mcircle_core
    import mcircle_pkg::*;
(
    input  t_gen_state  i_state,
    input  t_cmd_item   i_item,
    output t_gen_state  o_state,
    output t_pixel_item o_pixel
);

    t_radius next_major;
    t_radius next_minor;
    t_dec    next_dec;
    logic    step_ok;

    // One iteration of the midpoint loop, computed from the current state.
    always_comb begin
        t_dec two_minor;
        t_dec two_major;
        next_minor = i_state.minor + t_radius'(1);
        if (!i_state.decision[DEC_BITS-1] && (i_state.decision != '0)) begin
            next_major = i_state.major - t_radius'(1);
        end else begin
            next_major = i_state.major;
        end
        two_minor = $signed({2'b00, next_minor, 1'b0});
        two_major = $signed({2'b00, next_major, 1'b0});
        if (!i_state.decision[DEC_BITS-1] && (i_state.decision != '0)) begin
            next_dec = i_state.decision + two_minor - two_major + t_dec'(1);
        end else begin
            next_dec = i_state.decision + two_minor + t_dec'(1);
        end
        step_ok = (i_state.major > i_state.minor) && (next_major >= next_minor);
    end

    always_comb begin
        t_radius mag_x;
        t_radius mag_y;
        logic    neg_x;
        logic    neg_y;
        logic    end_grp;
        logic    last;
        logic    pix_valid;
        t_coord  base_x;
        t_coord  base_y;
        t_coord  off_x;
        t_coord  off_y;

        o_state   = i_state;
        mag_x     = '0;
        mag_y     = '0;
        neg_x     = 1'b0;
        neg_y     = 1'b0;
        end_grp   = 1'b0;
        last      = 1'b0;
        pix_valid = 1'b1;
        base_x    = i_state.cx;
        base_y    = i_state.cy;

        if (i_item.cmd == CMD_START) begin
            o_state.cx       = i_item.center_x;
            o_state.cy       = i_item.center_y;
            o_state.major    = i_item.radius;
            o_state.minor    = '0;
            o_state.decision = t_dec'(1) - $signed({3'b000, i_item.radius});
            base_x           = i_item.center_x;
            base_y           = i_item.center_y;
            mag_x            = i_item.radius;
            if (i_item.radius != '0) begin
                o_state.busy     = 1'b1;
                o_state.cardinal = 1'b1;
                o_state.idx      = IDX_CARD_WEST;
            end else begin
                o_state.busy     = 1'b0;
                o_state.cardinal = 1'b0;
                o_state.idx      = IDX_FIRST;
                last             = 1'b1;
            end
        end else if (!i_state.busy) begin
            pix_valid = 1'b0;
        end else if (i_state.cardinal) begin
            unique case (i_state.idx)
                IDX_CARD_WEST: begin
                    mag_x = i_state.major;
                    neg_x = 1'b1;
                end
                IDX_CARD_NORTH: begin
                    mag_y = i_state.major;
                end
                default: begin
                    mag_y   = i_state.major;
                    neg_y   = 1'b1;
                    end_grp = 1'b1;
                end
            endcase
            o_state.idx = i_state.idx + t_idx'(1);
        end else begin
            // Octant mirroring: the first four points swap nothing, the last four swap x and y.
            unique case (i_state.idx)
                3'd0: begin mag_x = i_state.major; mag_y = i_state.minor; end
                3'd1: begin mag_x = i_state.major; mag_y = i_state.minor; neg_x = 1'b1; end
                3'd2: begin mag_x = i_state.major; mag_y = i_state.minor; neg_y = 1'b1; end
                3'd3: begin
                    mag_x = i_state.major; mag_y = i_state.minor;
                    neg_x = 1'b1; neg_y = 1'b1;
                end
                3'd4: begin mag_x = i_state.minor; mag_y = i_state.major; end
                3'd5: begin mag_x = i_state.minor; mag_y = i_state.major; neg_x = 1'b1; end
                3'd6: begin mag_x = i_state.minor; mag_y = i_state.major; neg_y = 1'b1; end
                default: begin
                    mag_x = i_state.minor; mag_y = i_state.major;
                    neg_x = 1'b1; neg_y = 1'b1;
                end
            endcase
            end_grp = (i_state.idx == IDX_GROUP_END) ||
                      ((i_state.idx == IDX_MIRROR_END) && (i_state.major == i_state.minor));
            o_state.idx = i_state.idx + t_idx'(1);
        end

        if (end_grp) begin
            o_state.cardinal = 1'b0;
            o_state.idx      = IDX_FIRST;
            if (step_ok) begin
                o_state.major    = next_major;
                o_state.minor    = next_minor;
                o_state.decision = next_dec;
            end else begin
                o_state.busy = 1'b0;
                last         = 1'b1;
            end
        end

        off_x = neg_x ? -COORD_BITS'(mag_x) : COORD_BITS'(mag_x);
        off_y = neg_y ? -COORD_BITS'(mag_y) : COORD_BITS'(mag_y);

        if (pix_valid) begin
            o_pixel.pixel_x     = base_x + off_x;
            o_pixel.pixel_y     = base_y + off_y;
            o_pixel.pixel_valid = 1'b1;
            o_pixel.last_pixel  = last;
        end else begin
            o_pixel = '0;
        end
    end

endmodule

FILE: verif/midpoint_circle_outline_unit_tb.sv
// Self-checking testbench for the midpoint circle outline unit.
// It needs mcircle_pkg and the midpoint_circle_outline_unit RTL, and it reads no files.
// An in-bench pixel tracker predicts every pixel item and checks the pixel channel.
module midpoint_circle_outline_unit_tb
    import mcircle_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Roughly how many command items the run offers in total.
    localparam int ITEM_TARGET    = 450;
    // Cycles the pixel side refuses items during the back-pressure episode.
    localparam int HOLD_CYCLES    = 64;
    // Cycles without any handshake on either channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 2000;
    // Cycles to keep watching once nothing is expected; the result comes from a register.
    localparam int DRAIN_CYCLES   = 4;
    // Percentage of cycles in which either side idles outside the steady stretch.
    localparam int IDLE_PCT       = 30;

    // ------------------------------------------------------------------
    // Pixel tracker: carries its own copy of the generator state, works out
    // the pixel each accepted command produces, and checks the pixel channel
    // against the queue of pixels still owed.
    // ------------------------------------------------------------------
    class pixel_tracker;
        t_pixel_item owed_pixels[$];
        int          mismatches;

        t_coord      org_x;
        t_coord      org_y;
        int          major_off;
        int          minor_off;
        int          decision;
        t_idx        slot;
        bit          cardinal;
        bit          drawing;

        function new();
            mismatches = 0;
            org_x      = '0;
            org_y      = '0;
            major_off  = 0;
            minor_off  = 0;
            decision   = 0;
            slot       = IDX_FIRST;
            cardinal   = 1'b0;
            drawing    = 1'b0;
        endfunction

        function bit circle_active();
            return drawing;
        endfunction

        function int pending();
            return owed_pixels.size();
        endfunction

        // One pass of the midpoint loop. The offsets and the decision value
        // move only when the new iteration still yields points.
        function bit advance_octant();
            int na;
            int nb;
            int nd;
            na = major_off;
            nb = minor_off;
            nd = decision;
            if (!(na > nb)) begin
                return 1'b0;
            end
            nb = nb + 1;
            if (nd <= 0) begin
                nd = nd + 2 * nb + 1;
            end else begin
                na = na - 1;
                nd = nd + 2 * nb - 2 * na + 1;
            end
            if (na < nb) begin
                return 1'b0;
            end
            major_off = na;
            minor_off = nb;
            decision  = nd;
            return 1'b1;
        endfunction

        // Works out the pixel item that one accepted command produces.
        function t_pixel_item trace_next_pixel(t_cmd_item c);
            t_pixel_item px;
            int          dx;
            int          dy;
            int          u;
            int          v;
            bit          last;
            bit          group_done;
            px         = '0;
            dx         = 0;
            dy         = 0;
            last       = 1'b0;
            group_done = 1'b0;
            if (c.cmd == CMD_START) begin
                org_x     = c.center_x;
                org_y     = c.center_y;
                major_off = int'(c.radius);
                minor_off = 0;
                decision  = 1 - major_off;
                dx        = major_off;
                if (major_off > 0) begin
                    drawing  = 1'b1;
                    cardinal = 1'b1;
                    slot     = IDX_CARD_WEST;
                end else begin
                    drawing  = 1'b0;
                    cardinal = 1'b0;
                    slot     = IDX_FIRST;
                    last     = 1'b1;
                end
            end else if (!drawing) begin
                // An advance with no circle in progress gives an all-zero item.
                return px;
            end else if (cardinal) begin
                if (slot == IDX_CARD_WEST) begin
                    dx = -major_off;
                end else if (slot == IDX_CARD_NORTH) begin
                    dy = major_off;
                end else begin
                    dy         = -major_off;
                    group_done = 1'b1;
                end
                slot = slot + t_idx'(1);
            end else begin
                // Bit 2 of the slot swaps the offsets, bit 0 negates x, bit 1 negates y.
                u  = slot[2] ? minor_off : major_off;
                v  = slot[2] ? major_off : minor_off;
                dx = slot[0] ? -u : u;
                dy = slot[1] ? -v : v;
                if (slot == IDX_GROUP_END ||
                    (slot == IDX_MIRROR_END && major_off == minor_off)) begin
                    group_done = 1'b1;
                end
                slot = slot + t_idx'(1);
            end
            if (group_done) begin
                if (!advance_octant()) begin
                    drawing = 1'b0;
                    last    = 1'b1;
                end
                cardinal = 1'b0;
                slot     = IDX_FIRST;
            end
            px.pixel_x     = org_x + t_coord'(dx);
            px.pixel_y     = org_y + t_coord'(dy);
            px.pixel_valid = 1'b1;
            px.last_pixel  = last;
            return px;
        endfunction

        function void note_command(t_cmd_item c);
            owed_pixels = {owed_pixels, trace_next_pixel(c)};
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_pixel(t_pixel_item got);
            t_pixel_item want;
            if (owed_pixels.size() == 0) begin
                flag_mismatch($sformatf("pixel item with none owed: x=%0d y=%0d v=%0b l=%0b",
                                        got.pixel_x, got.pixel_y,
                                        got.pixel_valid, got.last_pixel));
                return;
            end
            want = owed_pixels.pop_front();
            if (got.pixel_valid !== want.pixel_valid) begin
                flag_mismatch($sformatf("pixel_valid got %0b want %0b",
                                        got.pixel_valid, want.pixel_valid));
            end
            if (got.last_pixel !== want.last_pixel) begin
                flag_mismatch($sformatf("last_pixel got %0b want %0b",
                                        got.last_pixel, want.last_pixel));
            end
            if (got.pixel_x !== want.pixel_x) begin
                flag_mismatch($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
            end
            if (got.pixel_y !== want.pixel_y) begin
                flag_mismatch($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // Signals and the block under test.
    // ------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_cmd_item   i_item;
    logic        o_valid;
    logic        i_ready;
    t_pixel_item o_item;

    pixel_tracker tracker = new();

    // Shared between the stimulus and the pixel-side process.
    bit steady      = 1'b0;   // no idling on either side while set
    bit hold_req    = 1'b0;   // asks the pixel side for one long hold-off
    int items_sent  = 0;
    int hold_left   = 0;
    int idle_cycles = 0;

    midpoint_circle_outline_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // Command side. All inputs change only just after a rising edge, so the
    // values seen at the falling edge are the ones the next rising edge uses.
    // That makes the falling edge a race-free place to see a handshake.
    // ------------------------------------------------------------------
    function bit pause_now();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    function t_cmd_item make_cmd(logic cmd, t_coord cx, t_coord cy, t_radius r);
        t_cmd_item c;
        c.cmd      = cmd;
        c.center_x = cx;
        c.center_y = cy;
        c.radius   = r;
        return c;
    endfunction

    // Offers one command item and returns at the rising edge that accepted it.
    // The item stays on the bus, unchanged and valid, until it is taken.
    task automatic send_cmd(input t_cmd_item c);
        bit taken;
        taken = 1'b0;
        while (pause_now()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= c;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end
        tracker.note_command(c);
        items_sent++;
    endtask

    // Starts a circle and then advances through it. The walk stops at the
    // last pixel, after max_adv advances, or at random with chance quit_pct,
    // which leaves the circle unfinished for the next start to abandon.
    // The ignored fields of an advance carry random bits.
    task automatic trace_circle(input t_coord cx, input t_coord cy, input t_radius r,
                                input int max_adv, input int quit_pct);
        int n;
        n = 0;
        send_cmd(make_cmd(CMD_START, cx, cy, r));
        while (tracker.circle_active() && n < max_adv && $urandom_range(99) >= quit_pct) begin
            send_cmd(make_cmd(CMD_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                              t_radius'($urandom)));
            n++;
        end
    endtask

    // ------------------------------------------------------------------
    // Pixel side: random ready, one long hold-off on request (counted here),
    // and no idling while the steady stretch is on.
    // ------------------------------------------------------------------
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_ready   <= 1'b0;
            end else begin
                i_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Every pixel item taken is checked against the oldest one still owed.
    initial begin
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                tracker.check_pixel(o_item);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("midpoint_circle_outline_unit test failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int  pick;
        bit  pressure_done;
        pressure_done = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Advance straight after reset: nothing in progress, so an all-zero item.
        send_cmd(make_cmd(CMD_ADVANCE, 16'sh7fff, -16'sh8000, '1));
        // Zero radius at both corners of the coordinate range: one pixel, flagged last.
        send_cmd(make_cmd(CMD_START, 16'sh7fff, -16'sh8000, '0));
        send_cmd(make_cmd(CMD_START, -16'sh8000, 16'sh7fff, '0));
        // Idle again after a zero-radius circle.
        send_cmd(make_cmd(CMD_ADVANCE, '0, '0, '0));
        // Radius one at the extreme corner, run to the end: x and y both wrap.
        trace_circle(16'sh7fff, -16'sh8000, t_radius'(1), 100, 0);
        // Largest radius, a few pixels in, then abandoned by a new start that
        // is run to completion.
        trace_circle(-16'sh8000, -16'sh8000, '1, 5, 0);
        trace_circle('0, '0, t_radius'(1), 100, 0);

        // Random part: mostly complete small circles with random centers,
        // plus large abandoned circles, stray advances and stray starts.
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 120 && !pressure_done) begin
                // The sender keeps offering while the pixel side holds off,
                // so the result register fills and the command side stalls.
                hold_req      = 1'b1;
                pressure_done = 1'b1;
            end
            steady = (items_sent >= 250 && items_sent < 330);
            pick   = $urandom_range(99);
            if (pick < 75) begin
                trace_circle(t_coord'($urandom), t_coord'($urandom),
                             t_radius'($urandom_range(0, 9)), 200, 3);
            end else if (pick < 82) begin
                trace_circle(t_coord'($urandom), t_coord'($urandom),
                             t_radius'($urandom), 30, 0);
            end else if (pick < 92) begin
                send_cmd(make_cmd(CMD_ADVANCE, t_coord'($urandom), t_coord'($urandom),
                                  t_radius'($urandom)));
            end else begin
                send_cmd(make_cmd(CMD_START, t_coord'($urandom), t_coord'($urandom),
                                  t_radius'($urandom)));
            end
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        // Drain: wait for every owed pixel, then watch a few more cycles for
        // anything extra. The watchdog bounds this wait.
        while (tracker.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0) begin
            $display("midpoint_circle_outline_unit test passed");
        end else begin
            $display("midpoint_circle_outline_unit test failed");
        end
        $finish;
    end

endmodule
